@@ rtl/core/sgsd_pkg.sv @@
// ---------------------------------------------------------------------------
// sgsd_pkg - shared types and constants of the silence gate split detector
// Payload structs for both channels, the live register set, register indexes
// and edge codes.
// ---------------------------------------------------------------------------
package sgsd_pkg;

  // field widths fixed by the data format
  localparam int SAMPLE_W = 8;
  localparam int PEAK_W   = 7;
  localparam int COUNT_W  = 6;
  localparam int FRAME_W  = 32;
  localparam int IDX_W    = 3;
  // scan counters: window never exceeds 2**COUNT_W entries
  localparam int CNT_W    = COUNT_W + 1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ATTACK_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ATTACK_COUNT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE_LEVEL = 3'd2;
  localparam logic [IDX_W-1:0] REG_RELEASE_COUNT = 3'd3;
  localparam logic [IDX_W-1:0] REG_FIRST_FRAME   = 3'd4;

  // register reset values
  localparam logic [PEAK_W-1:0]  ATTACK_LEVEL_RST  = 7'd5;
  localparam logic [COUNT_W-1:0] ATTACK_COUNT_RST  = 6'd2;
  localparam logic [PEAK_W-1:0]  RELEASE_LEVEL_RST = 7'd2;
  localparam logic [COUNT_W-1:0] RELEASE_COUNT_RST = 6'd5;
  localparam logic [FRAME_W-1:0] FIRST_FRAME_RST   = 32'd0;

  // edge kinds
  localparam logic EDGE_ATTACK  = 1'b0;
  localparam logic EDGE_RELEASE = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_present;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] split_frame;
    logic               edge_kind;
  } out_item_t;

  // live gate settings plus the frame counter load strobe
  typedef struct packed {
    logic [PEAK_W-1:0]  attack_level;
    logic [COUNT_W-1:0] attack_count;
    logic [PEAK_W-1:0]  release_level;
    logic [COUNT_W-1:0] release_count;
    logic               ff_load;
    logic [FRAME_W-1:0] ff_value;
  } cfg_t;

endpackage

@@ rtl/core/sgsd_ram.sv @@
// ---------------------------------------------------------------------------
// sgsd_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sgsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sgsd_front.sv @@
// ---------------------------------------------------------------------------
// sgsd_front - sample intake and frame peak tracking
// Keeps the running peak of the open frame and, on the closing beat, hands
// the finished frame peak to the job queue.
// ---------------------------------------------------------------------------
module sgsd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sgsd_pkg::in_item_t        in_data,
  output logic                      q_push,
  output logic [sgsd_pkg::PEAK_W-1:0] q_peak,
  input  logic                      q_full
);

  logic [sgsd_pkg::PEAK_W-1:0] peak_r;
  logic [sgsd_pkg::PEAK_W-1:0] peak_nxt;
  logic [sgsd_pkg::PEAK_W-1:0] peak_upd;
  logic                        accept;

  // running peak, floored at zero: negative samples never raise it
  always_comb begin
    accept   = in_valid && !q_full;
    peak_upd = peak_r;
    if (in_data.sample_present && !in_data.sample[sgsd_pkg::SAMPLE_W-1] &&
        (in_data.sample[sgsd_pkg::PEAK_W-1:0] > peak_r)) begin
      peak_upd = in_data.sample[sgsd_pkg::PEAK_W-1:0];
    end
    peak_nxt = peak_r;
    if (accept) begin
      peak_nxt = in_data.frame_end ? '0 : peak_upd;
    end
  end

  assign in_stall = q_full;
  assign q_push   = accept && in_data.frame_end;
  assign q_peak   = peak_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

endmodule

@@ rtl/core/sgsd_fifo.sv @@
// ---------------------------------------------------------------------------
// sgsd_fifo - two-entry job queue between intake and gate evaluation
// Holds finished frame peaks so both sides can stall independently.
// ---------------------------------------------------------------------------
module sgsd_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [sgsd_pkg::PEAK_W-1:0] push_data,
  output logic                        full,
  input  logic                        pop,
  output logic [sgsd_pkg::PEAK_W-1:0] pop_data,
  output logic                        empty
);

  logic [sgsd_pkg::PEAK_W-1:0] mem_r [2];
  logic                        wp_r;
  logic                        rp_r;
  logic [1:0]                  cnt_r;
  logic [1:0]                  cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/sgsd_back.sv @@
// ---------------------------------------------------------------------------
// sgsd_back - gate evaluation over the window of frame peaks
// Writes each frame peak into the window RAM, scans the newest W entries
// one per cycle when an attack or release test is due, and issues the split beat.
// ---------------------------------------------------------------------------
module sgsd_back #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgsd_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [sgsd_pkg::PEAK_W-1:0] q_peak,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sgsd_pkg::out_item_t         out_data
);

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int WIN_CAP = (MAX_WINDOW < (1 << sgsd_pkg::COUNT_W)) ?
                           MAX_WINDOW : (1 << sgsd_pkg::COUNT_W);
  localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_WINDOW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]                   state_r, state_nxt;
  logic [AW-1:0]                head_r, head_inc;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [MAX_WINDOW-1:0]        valid_r;
  logic [sgsd_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [sgsd_pkg::CNT_W-1:0]   last_r;
  logic [sgsd_pkg::CNT_W-1:0]   rd_k_r;
  logic                         rd_live_r;
  logic                         rd_vld_r;
  logic [sgsd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sgsd_pkg::CNT_W-1:0]   cut_r, cut_nxt;
  logic                         scan_go_r;
  logic                         scan_atk_r;
  logic                         in_attack_r;
  logic                         in_release_r;
  logic [sgsd_pkg::FRAME_W-1:0] frame_r;
  logic                         out_valid_r;
  sgsd_pkg::out_item_t          out_data_r;

  logic [sgsd_pkg::PEAK_W-1:0]  rdata;
  logic [sgsd_pkg::PEAK_W-1:0]  entry;
  logic [sgsd_pkg::COUNT_W-1:0] wmax;
  logic [sgsd_pkg::CNT_W-1:0]   wlen;
  logic                         atk_go;
  logic                         rel_go;
  logic                         hit;
  logic [sgsd_pkg::COUNT_W-1:0] need;
  logic                         fire;
  logic                         out_free;
  logic                         finish;

  // window storage
  sgsd_ram #(
    .WIDTH (sgsd_pkg::PEAK_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (q_pop),
    .waddr (head_inc),
    .wdata (q_peak),
    .raddr (addr_r),
    .rdata (rdata)
  );

  // window length and the edge to test for this frame
  always_comb begin
    head_inc = (head_r == ADDR_TOP) ? '0 : head_r + AW'(1);
    wmax     = (cfg.attack_count > cfg.release_count) ? cfg.attack_count : cfg.release_count;
    wlen     = {1'b0, wmax} + sgsd_pkg::CNT_W'(1);
    if (wlen > sgsd_pkg::CNT_W'(WIN_CAP)) begin
      wlen = sgsd_pkg::CNT_W'(WIN_CAP);
    end
    atk_go = (q_peak >= cfg.attack_level) && !in_attack_r;
    rel_go = !atk_go && (q_peak < cfg.release_level) && !in_release_r;
  end

  // entry that came back from the RAM; never-written entries read as zero
  always_comb begin
    entry = rd_vld_r ? rdata : '0;
    hit   = scan_atk_r ? (entry > cfg.attack_level) : (entry < cfg.release_level);
    cnt_nxt = cnt_r;
    cut_nxt = cut_r;
    if (rd_live_r && hit) begin
      cnt_nxt = cnt_r + sgsd_pkg::CNT_W'(1);
      cut_nxt = rd_k_r + sgsd_pkg::CNT_W'(1);
    end
  end

  // decision and output hand-off
  always_comb begin
    need     = scan_atk_r ? cfg.attack_count : cfg.release_count;
    fire     = scan_go_r && (cnt_r >= {1'b0, need});
    out_free = !out_valid_r || !out_stall;
    finish   = (state_r == S_DONE) && (!fire || out_free);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          addr_nxt = head_inc;
          k_nxt    = '0;
          state_nxt = (atk_go || rel_go) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        addr_nxt = (addr_r == '0) ? ADDR_TOP : addr_r - AW'(1);
        k_nxt    = k_r + sgsd_pkg::CNT_W'(1);
        if (k_r == last_r) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      valid_r      <= '0;
      rd_live_r    <= 1'b0;
      scan_go_r    <= 1'b0;
      scan_atk_r   <= 1'b0;
      in_attack_r  <= 1'b0;
      in_release_r <= 1'b0;
      frame_r      <= sgsd_pkg::FIRST_FRAME_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_live_r <= (state_r == S_SCAN);
      if (q_pop) begin
        head_r            <= head_inc;
        valid_r[head_inc] <= 1'b1;
        scan_go_r         <= atk_go || rel_go;
        scan_atk_r        <= atk_go;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (finish) begin
        frame_r <= frame_r + sgsd_pkg::FRAME_W'(1);
        if (fire) begin
          out_valid_r  <= 1'b1;
          in_attack_r  <= scan_atk_r;
          in_release_r <= !scan_atk_r;
        end
      end
      if (cfg.ff_load) begin
        frame_r <= cfg.ff_value;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    k_r      <= k_nxt;
    rd_k_r   <= k_r;
    rd_vld_r <= valid_r[addr_r];
    if (q_pop) begin
      last_r <= wlen - sgsd_pkg::CNT_W'(1);
      cnt_r  <= '0;
      cut_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      cut_r <= cut_nxt;
    end
    if (finish && fire) begin
      out_data_r.split_frame <= scan_atk_r ?
                                frame_r - {{(sgsd_pkg::FRAME_W-sgsd_pkg::CNT_W){1'b0}}, cut_r} :
                                frame_r;
      out_data_r.edge_kind   <= scan_atk_r ? sgsd_pkg::EDGE_ATTACK : sgsd_pkg::EDGE_RELEASE;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/silence_gate_split_detector.sv @@
// Flow: a closing beat goes through the job queue to the evaluator, which scans
//   the newest W entries when a test is due and registers any split beat,
//   W = min(max(attack_count, release_count) + 1, MAX_WINDOW).
// Throughput: one sample beat per cycle unless the two-entry job queue is full;
//   the evaluator reads one window entry per cycle, one frame at a time.
// Reset: synchronous, active low; the window reads as zero at once via valid bits.
// ---------------------------------------------------------------------------
// silence_gate_split_detector - noise gate split detector, top level
// Register bank for the gate settings, sample intake, job queue and the
// window evaluator.
// ---------------------------------------------------------------------------
module silence_gate_split_detector #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sgsd_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sgsd_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sgsd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sgsd_pkg::FRAME_W-1:0] cfg_wdata
);

  logic [sgsd_pkg::PEAK_W-1:0]  attack_level_r;
  logic [sgsd_pkg::COUNT_W-1:0] attack_count_r;
  logic [sgsd_pkg::PEAK_W-1:0]  release_level_r;
  logic [sgsd_pkg::COUNT_W-1:0] release_count_r;
  logic                         cfg_wr;
  logic                         ff_load;
  sgsd_pkg::cfg_t               cfg;

  logic                         q_push;
  logic [sgsd_pkg::PEAK_W-1:0]  q_push_peak;
  logic                         q_full;
  logic                         q_pop;
  logic [sgsd_pkg::PEAK_W-1:0]  q_pop_peak;
  logic                         q_empty;

  // register bank: writes always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ff_load   = cfg_wr && (cfg_index == sgsd_pkg::REG_FIRST_FRAME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_level_r  <= sgsd_pkg::ATTACK_LEVEL_RST;
      attack_count_r  <= sgsd_pkg::ATTACK_COUNT_RST;
      release_level_r <= sgsd_pkg::RELEASE_LEVEL_RST;
      release_count_r <= sgsd_pkg::RELEASE_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        sgsd_pkg::REG_ATTACK_LEVEL:  attack_level_r  <= cfg_wdata[sgsd_pkg::PEAK_W-1:0];
        sgsd_pkg::REG_ATTACK_COUNT:  attack_count_r  <= cfg_wdata[sgsd_pkg::COUNT_W-1:0];
        sgsd_pkg::REG_RELEASE_LEVEL: release_level_r <= cfg_wdata[sgsd_pkg::PEAK_W-1:0];
        sgsd_pkg::REG_RELEASE_COUNT: release_count_r <= cfg_wdata[sgsd_pkg::COUNT_W-1:0];
        default: begin
          // first_frame goes straight to the frame counter; others ignored
        end
      endcase
    end
  end

  always_comb begin
    cfg.attack_level  = attack_level_r;
    cfg.attack_count  = attack_count_r;
    cfg.release_level = release_level_r;
    cfg.release_count = release_count_r;
    cfg.ff_load       = ff_load;
    cfg.ff_value      = cfg_wdata;
  end

  // intake
  sgsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_peak   (q_push_peak),
    .q_full   (q_full)
  );

  // job queue
  sgsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_peak),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_peak),
    .empty     (q_empty)
  );

  // window evaluator
  sgsd_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_peak    (q_pop_peak),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
